[hw/rtl/wstm_pkg.sv]
// Shared types and constants for the wheel speed and trip meter.
package wstm_pkg;

  // Register and field widths
  localparam int CIRC_W            = 12;
  localparam int OFFSET_W          = 16;
  localparam int CPU_W             = 11;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int KIND_W            = 2;
  localparam int PERIOD_COUNT_BITS = 16;
  localparam int SPEED_W           = 20;
  localparam int DISTANCE_BITS     = 40;
  localparam int RIDE_W            = 32;

  // Derived datapath widths
  localparam int PROD_W      = PERIOD_COUNT_BITS + CPU_W;
  localparam int PERIOD_W    = PROD_W + 1;
  localparam int US_PER_S_W  = 20;
  localparam int DIVIDEND_W  = CIRC_W + US_PER_S_W;
  localparam int DIV_CNT_W   = $clog2(SPEED_W);
  localparam int US_PER_S    = 1000000;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Register reset values
  localparam logic [CIRC_W-1:0]   CIRC_RST     = CIRC_W'(2234);
  localparam logic [OFFSET_W-1:0] DEBOUNCE_RST = OFFSET_W'(5000);
  localparam logic [CPU_W-1:0]    CPU_RST      = CPU_W'(128);

  typedef enum logic [KIND_W-1:0] {
    KIND_PULSE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIRC         = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_COUNT_PERIOD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CIRC_W-1:0]   circ;
    logic [OFFSET_W-1:0] offset;
    logic [CPU_W-1:0]    cpu;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

endpackage

[hw/rtl/wstm_front.sv]
// Front end: accepts items, forms the revolution period and queues a command.
module wstm_front
  import wstm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [KIND_W-1:0]            kind_i,
  input  logic [PERIOD_COUNT_BITS-1:0] period_count_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output cmd_t                         push_cmd_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  front_state_e                 state_q, state_d;
  logic [KIND_W-1:0]            kind_q, kind_d;
  logic [PERIOD_COUNT_BITS-1:0] count_q, count_d;
  logic [PROD_W-1:0]            prod_q, prod_d;

  assign in_ready_o          = (state_q == F_IDLE);
  assign push_valid_o        = (state_q == F_PUSH);
  assign push_cmd_o.kind     = kind_q;
  assign push_cmd_o.period   = PERIOD_W'(cfg_i.offset) + PERIOD_W'(prod_q);

  // Classify: only pulses need the period product
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    count_d = count_q;
    prod_d  = prod_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          count_d = period_count_i;
          prod_d  = '0;
          state_d = (kind_i == KIND_PULSE) ? F_MUL : F_PUSH;
        end
      end
      F_MUL: begin
        prod_d  = PROD_W'(count_q) * PROD_W'(cfg_i.cpu);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      kind_q  <= '0;
      count_q <= '0;
      prod_q  <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      count_q <= count_d;
      prod_q  <= prod_d;
    end
  end

endmodule

[hw/rtl/wstm_queue.sv]
// Short command queue decoupling the front end from the back end.
module wstm_queue
  import wstm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;
  logic                   push, pop;

  assign push_ready_o = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hw/rtl/wstm_back.sv]
// Back end: serial speed divider, trip state and result register.
module wstm_back
  import wstm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  cmd_t                     cmd_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SPEED_W-1:0]       speed_mm_per_s_o,
  output logic [SPEED_W-1:0]       max_speed_mm_per_s_o,
  output logic [DISTANCE_BITS-1:0] distance_mm_o,
  output logic [RIDE_W-1:0]        ride_seconds_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CHK,
    B_DIV,
    B_OUT
  } back_state_e;

  back_state_e               state_q, state_d;
  logic [KIND_W-1:0]         kind_q, kind_d;
  logic [PERIOD_W-1:0]       period_q, period_d;
  logic [DIVIDEND_W-1:0]     dividend_q, dividend_d;
  logic [PERIOD_W:0]         rem_q, rem_d;
  logic [SPEED_W-1:0]        low_q, low_d;
  logic [SPEED_W-1:0]        quo_q, quo_d;
  logic [DIV_CNT_W-1:0]      cnt_q, cnt_d;

  logic [SPEED_W-1:0]        cur_q, cur_d;
  logic [SPEED_W-1:0]        max_q, max_d;
  logic [DISTANCE_BITS-1:0]  dist_q, dist_d;
  logic [RIDE_W-1:0]         ride_q, ride_d;

  logic                      out_valid_q, out_valid_d;
  logic [SPEED_W-1:0]        o_speed_q, o_speed_d;
  logic [SPEED_W-1:0]        o_max_q, o_max_d;
  logic [DISTANCE_BITS-1:0]  o_dist_q, o_dist_d;
  logic [RIDE_W-1:0]         o_ride_q, o_ride_d;

  logic [PERIOD_W:0]         rem_sh;
  logic                      rem_ge;
  logic [PERIOD_W-1:0]       div_hi;
  logic                      sat;
  logic [DISTANCE_BITS:0]    dist_sum;
  logic                      out_free;

  assign cmd_ready_o          = (state_q == B_IDLE);
  assign out_valid_o          = out_valid_q;
  assign speed_mm_per_s_o     = o_speed_q;
  assign max_speed_mm_per_s_o = o_max_q;
  assign distance_mm_o        = o_dist_q;
  assign ride_seconds_o       = o_ride_q;

  // One restoring division step
  assign rem_sh = {rem_q[PERIOD_W-1:0], low_q[SPEED_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, period_q});

  // Quotient overflows 20 bits when the high dividend part reaches the period
  assign div_hi = PERIOD_W'(dividend_q[DIVIDEND_W-1:SPEED_W]);
  assign sat    = (period_q == '0) || (div_hi >= period_q);

  assign dist_sum = {1'b0, dist_q} + (DISTANCE_BITS + 1)'(cur_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    period_d    = period_q;
    dividend_d  = dividend_q;
    rem_d       = rem_q;
    low_d       = low_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    max_d       = max_q;
    dist_d      = dist_q;
    ride_d      = ride_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_speed_d   = o_speed_q;
    o_max_d     = o_max_q;
    o_dist_d    = o_dist_q;
    o_ride_d    = o_ride_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          kind_d   = cmd_i.kind;
          period_d = cmd_i.period;
          state_d  = (cmd_i.kind == KIND_PULSE) ? B_MUL : B_OUT;
        end
      end
      B_MUL: begin
        dividend_d = DIVIDEND_W'(cfg_i.circ) * DIVIDEND_W'(US_PER_S);
        state_d    = B_CHK;
      end
      B_CHK: begin
        if (sat) begin
          quo_d   = '1;
          state_d = B_OUT;
        end else begin
          rem_d   = (PERIOD_W + 1)'(dividend_q[DIVIDEND_W-1:SPEED_W]);
          low_d   = dividend_q[SPEED_W-1:0];
          quo_d   = '0;
          cnt_d   = DIV_CNT_W'(SPEED_W - 1);
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        rem_d = rem_ge ? (rem_sh - {1'b0, period_q}) : rem_sh;
        low_d = {low_q[SPEED_W-2:0], 1'b0};
        quo_d = {quo_q[SPEED_W-2:0], rem_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          o_speed_d = cur_q;
          o_max_d   = max_q;
          o_dist_d  = dist_q;
          o_ride_d  = ride_q;
          case (kind_q)
            KIND_PULSE: begin
              cur_d     = quo_q;
              o_speed_d = quo_q;
            end
            KIND_TICK: begin
              if (cur_q > max_q) begin
                max_d   = cur_q;
                o_max_d = cur_q;
              end
              if (cur_q != '0 && ride_q != '1) begin
                ride_d   = ride_q + 1'b1;
                o_ride_d = ride_q + 1'b1;
              end
              dist_d   = dist_sum[DISTANCE_BITS] ? '1 : dist_sum[DISTANCE_BITS-1:0];
              o_dist_d = dist_sum[DISTANCE_BITS] ? '1 : dist_sum[DISTANCE_BITS-1:0];
              cur_d    = '0;
            end
            KIND_CLEAR: begin
              max_d    = '0;
              dist_d   = '0;
              ride_d   = '0;
              o_max_d  = '0;
              o_dist_d = '0;
              o_ride_d = '0;
            end
            default: ;  // unknown kind only reports the state
          endcase
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      kind_q      <= '0;
      period_q    <= '0;
      dividend_q  <= '0;
      rem_q       <= '0;
      low_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      cur_q       <= '0;
      max_q       <= '0;
      dist_q      <= '0;
      ride_q      <= '0;
      out_valid_q <= 1'b0;
      o_speed_q   <= '0;
      o_max_q     <= '0;
      o_dist_q    <= '0;
      o_ride_q    <= '0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      period_q    <= period_d;
      dividend_q  <= dividend_d;
      rem_q       <= rem_d;
      low_q       <= low_d;
      quo_q       <= quo_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      max_q       <= max_d;
      dist_q      <= dist_d;
      ride_q      <= ride_d;
      out_valid_q <= out_valid_d;
      o_speed_q   <= o_speed_d;
      o_max_q     <= o_max_d;
      o_dist_q    <= o_dist_d;
      o_ride_q    <= o_ride_d;
    end
  end

endmodule

[hw/rtl/wheel_speed_trip_meter_unit.sv]
// Top level of the wheel speed and trip meter.
// Flow: a wheel pulse goes through the front multiply, the queue, the back multiply,
// saturation check and 20-step serial divider (the divider is skipped when the speed
// saturates); ticks, clears and unknown kinds skip the multiply and divide states.
// Front and back each hold one item at a time; neither takes another until it is done.
// Reset: asynchronous, active low; speed, trip values and queue clear, registers
// return to circumference 2234 mm, debounce 5000 us, 128 us per count.
module wheel_speed_trip_meter_unit
  import wstm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [KIND_W-1:0]            kind_i,
  input  logic [PERIOD_COUNT_BITS-1:0] period_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SPEED_W-1:0]           speed_mm_per_s_o,
  output logic [SPEED_W-1:0]           max_speed_mm_per_s_o,
  output logic [DISTANCE_BITS-1:0]     distance_mm_o,
  output logic [RIDE_W-1:0]            ride_seconds_o
);

  cfg_t cfg_q;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.circ   <= CIRC_RST;
      cfg_q.offset <= DEBOUNCE_RST;
      cfg_q.cpu    <= CPU_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CIRC:         cfg_q.circ   <= cfg_data_i[CIRC_W-1:0];
        CFG_DEBOUNCE:     cfg_q.offset <= cfg_data_i[OFFSET_W-1:0];
        CFG_COUNT_PERIOD: cfg_q.cpu    <= cfg_data_i[CPU_W-1:0];
        default: ;
      endcase
    end
  end

  wstm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .period_count_i (period_count_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_cmd_o     (push_cmd)
  );

  wstm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_cmd_o    (cmd)
  );

  wstm_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .cmd_valid_i          (cmd_valid),
    .cmd_ready_o          (cmd_ready),
    .cmd_i                (cmd),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .speed_mm_per_s_o     (speed_mm_per_s_o),
    .max_speed_mm_per_s_o (max_speed_mm_per_s_o),
    .distance_mm_o        (distance_mm_o),
    .ride_seconds_o       (ride_seconds_o)
  );

`ifndef SYNTH
  // Front end is busy in the cycle after taking a beat
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front accepted back-to-back beats");

  // Back end is busy in the cycle after popping a command
  a_back_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("back end popped back-to-back commands");

  // A full queue always reports a command to pop
  a_queue_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && !push_ready |-> cmd_valid)
    else $error("queue full yet reports empty");
`endif

endmodule
